### design/tps_pkg.sv
// shared types, constants and helpers of the two-piece sixth-order spline block
// no dependencies; imported by tps_mulq and the top level
`timescale 1ns / 1ps

package tps_pkg;

	localparam int SEGMENTS = 2;
	localparam int TERMS    = 7;
	localparam int COEF_W   = 48;
	localparam int DEPTH    = SEGMENTS * TERMS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int J_W      = $clog2(TERMS);
	localparam int REG_W    = 3;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_LIFTOFF   = 3'd0;
	localparam logic [REG_W-1:0] REG_APEX      = 3'd1;
	localparam logic [REG_W-1:0] REG_TOUCHDOWN = 3'd2;
	localparam logic [REG_W-1:0] REG_LEFT_INV  = 3'd3;
	localparam logic [REG_W-1:0] REG_RIGHT_INV = 3'd4;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic signed [COEF_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [COEF_W-1:0] MIN48 = 48'sh8000_0000_0000;
	localparam logic [16:0]              ONE_Q = 17'd65536;

	typedef struct packed {
		logic               operation;
		logic               segment;
		logic signed [31:0] start_position;
		logic signed [31:0] start_velocity;
		logic signed [31:0] start_acceleration;
		logic signed [31:0] middle_height;
		logic signed [31:0] end_position;
		logic signed [31:0] end_velocity;
		logic signed [31:0] end_acceleration;
		logic        [31:0] query_time;
	} in_t;

	typedef struct packed {
		logic signed [31:0] position_out;
		logic signed [31:0] velocity_out;
		logic signed [31:0] acceleration_out;
		logic               time_clamped;
	} out_t;

	// doubled coefficient weights, row = coefficient, column = term
	// term order: x1, v1, a1, x2, x3, v3, a3
	localparam logic signed [9:0] LOAD_W [TERMS][TERMS] = '{
		'{ 10'sd2,   10'sd0,   10'sd0,  10'sd0,    10'sd0,    10'sd0,   10'sd0 },
		'{ 10'sd0,   10'sd2,   10'sd0,  10'sd0,    10'sd0,    10'sd0,   10'sd0 },
		'{ 10'sd0,   10'sd0,   10'sd1,  10'sd0,    10'sd0,    10'sd0,   10'sd0 },
		'{-10'sd84, -10'sd32, -10'sd5,  10'sd128, -10'sd44,   10'sd12, -10'sd1 },
		'{ 10'sd222, 10'sd76,  10'sd9, -10'sd384,  10'sd162, -10'sd46,  10'sd4 },
		'{-10'sd204,-10'sd66, -10'sd7,  10'sd384, -10'sd180,  10'sd54, -10'sd5 },
		'{ 10'sd64,  10'sd20,  10'sd2, -10'sd128,  10'sd64,  -10'sd20,  10'sd2 }
	};

	// derivative factors: row = derivative order, column = power
	localparam logic [4:0] DERIV_F [3][TERMS] = '{
		'{5'd1, 5'd1, 5'd1, 5'd1, 5'd1,  5'd1,  5'd1},
		'{5'd0, 5'd1, 5'd2, 5'd3, 5'd4,  5'd5,  5'd6},
		'{5'd0, 5'd0, 5'd2, 5'd6, 5'd12, 5'd20, 5'd30}
	};

	function automatic logic signed [COEF_W-1:0] sat48(input logic signed [63:0] x);
		if (x > 64'(MAX48))
			return MAX48;
		else if (x < 64'(MIN48))
			return MIN48;
		else
			return x[COEF_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [COEF_W-1:0] x);
		if (x > 48'sh0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (x < -48'sh0000_8000_0000)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

endpackage

### design/tps_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module tps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### design/tps_mulq.sv
// shared q16.16 multiplier: floor(a*b/2^16) saturated to 48 bits
// one 32x32 multiplier over two partial products; uses tps_pkg
`timescale 1ns / 1ps

module tps_mulq import tps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [COEF_W-1:0] a,
	input  logic        [31:0]       b,
	output logic                     done,
	output logic signed [COEF_W-1:0] res
);

	typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_FIN} phase_t;

	localparam logic [63:0] LIM_POS = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;

	phase_t                  ph_q;
	logic                    neg_q;
	logic [COEF_W-1:0]       mag_q;
	logic [31:0]             b_q;
	logic [COEF_W-1:0]       lo_q;
	logic [63:0]             hi_q;
	logic                    done_q;
	logic signed [COEF_W-1:0] res_q;

	logic [31:0] op;
	logic [63:0] prod;
	logic [63:0] q;
	logic [63:0] qn;
	logic signed [COEF_W-1:0] res_n;

	assign op   = (ph_q == PH_LO) ? {16'b0, mag_q[15:0]} : mag_q[47:16];
	assign prod = 64'(op) * 64'(b_q);
	assign q    = hi_q + {16'b0, lo_q[47:16]};
	assign qn   = q + {63'b0, |lo_q[15:0]};

	always_comb begin
		if (!neg_q)
			res_n = (q > LIM_POS) ? MAX48 : q[COEF_W-1:0];
		else
			res_n = (qn > LIM_NEG) ? MIN48 : -qn[COEF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						neg_q <= a[COEF_W-1];
						mag_q <= a[COEF_W-1] ? -a : a;
						b_q   <= b;
						ph_q  <= PH_LO;
					end
				end
				PH_LO: begin
					lo_q <= prod[COEF_W-1:0];
					ph_q <= PH_HI;
				end
				PH_HI: begin
					hi_q <= prod;
					ph_q <= PH_FIN;
				end
				PH_FIN: begin
					res_q  <= res_n;
					done_q <= 1'b1;
					ph_q   <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### design/two_piece_sixth_order_spline_top.sv
// top level of the two-piece sixth-order swing spline
// uses tps_pkg, tps_ram (coefficient store) and tps_mulq (shared multiplier)
`timescale 1ns / 1ps

// Channels: in_valid/in_ready/in_data take one beat per item, out_valid/
// out_ready/out_data give one beat per evaluate item. A load beat (operation
// load) scales the boundary conditions by the segment duration, forms the
// seven coefficients and writes them to the coefficient ram; it gives no
// result beat. It makes six passes through the shared multiplier, then forms
// each coefficient as a weighted sum over the seven terms.
// An evaluate beat clamps and normalizes the query time, runs three Horner
// passes (position, velocity, acceleration) reading one coefficient per step
// from the ram, and scales the velocity and acceleration results by the
// reciprocal duration; its pace is set by the one 32x32 multiplier that every
// step but the first of each pass goes through in two partial products. Items
// are handled one at a time: in_ready is high only between items. The result
// sits in an output register; the next item is accepted while it waits. If
// the receiver still stalls when the next result is ready, the block holds in
// its last step until out_ready. Reset clears the configuration to its
// defaults and marks both segments as not loaded; a segment never loaded
// reads as all-zero coefficients, so no clearing pass runs. Configuration is
// written through cfg_we/cfg_index/cfg_data, one register per cycle; the user
// must write it only while the block is idle, as the block does not enforce it.
module two_piece_sixth_order_spline_top import tps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_LMUL, S_LWAIT, S_LSUM,
		S_EPREP, S_ETN, S_ETNW, S_ERD, S_ESC, S_EHW, S_EFS, S_EFW, S_EOUT
	} state_t;

	// load multiply steps
	localparam logic [2:0] MI_V1  = 3'd0;
	localparam logic [2:0] MI_SA  = 3'd1;
	localparam logic [2:0] MI_A1  = 3'd2;
	localparam logic [2:0] MI_V3  = 3'd3;
	localparam logic [2:0] MI_EA  = 3'd4;
	localparam logic [2:0] MI_A3  = 3'd5;

	// term slots
	localparam logic [J_W-1:0] T_X1 = 3'd0;
	localparam logic [J_W-1:0] T_V1 = 3'd1;
	localparam logic [J_W-1:0] T_A1 = 3'd2;
	localparam logic [J_W-1:0] T_X2 = 3'd3;
	localparam logic [J_W-1:0] T_X3 = 3'd4;
	localparam logic [J_W-1:0] T_V3 = 3'd5;
	localparam logic [J_W-1:0] T_A3 = 3'd6;
	localparam logic [J_W-1:0] J_TOP = J_W'(TERMS - 1);

	// configuration
	logic [31:0] lift_q, apex_q, touch_q, linv_q, rinv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_q  <= 32'd0;
			apex_q  <= 32'd65536;
			touch_q <= 32'd131072;
			linv_q  <= 32'd65536;
			rinv_q  <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIFTOFF:   lift_q  <= cfg_data;
				REG_APEX:      apex_q  <= cfg_data;
				REG_TOUCHDOWN: touch_q <= cfg_data;
				REG_LEFT_INV:  linv_q  <= cfg_data;
				REG_RIGHT_INV: rinv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t                    state_q;
	in_t                       in_q;
	logic                      seg_q;
	logic [31:0]               dt_q;
	logic signed [COEF_W-1:0]  term_q [TERMS];
	logic signed [COEF_W-1:0]  tmp_q;
	logic [2:0]                mi_q;
	logic [J_W-1:0]            k_q;
	logic [J_W-1:0]            j_q;
	logic signed [63:0]        lacc_q;
	logic [SEGMENTS-1:0]       loaded_q;
	logic                      clamped_q;
	logic [31:0]               inv_q;
	logic [31:0]               d_q;
	logic [16:0]               tn_q;
	logic [1:0]                m_q;
	logic [1:0]                fcnt_q;
	logic signed [COEF_W-1:0]  p_q;
	logic signed [COEF_W-1:0]  scaled_q;
	logic signed [COEF_W-1:0]  pos_q;
	logic signed [COEF_W-1:0]  vel_q;
	out_t                      out_q;
	logic                      out_valid_q;

	// shared multiplier
	logic                      mul_start;
	logic signed [COEF_W-1:0]  mul_a;
	logic [31:0]               mul_b;
	logic                      mul_done;
	logic signed [COEF_W-1:0]  mul_res;

	tps_mulq u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	// coefficient store
	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [COEF_W-1:0]         ram_wdata;
	logic [COEF_W-1:0]         ram_rdata;
	logic signed [COEF_W-1:0]  rd_coef;

	tps_ram #(
		.WIDTH (COEF_W),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// a segment not yet loaded reads as zero
	assign rd_coef = loaded_q[seg_q] ? signed'(ram_rdata) : '0;

	function automatic logic [ADDR_W-1:0] addr_of(input logic seg, input logic [J_W-1:0] j);
		return ADDR_W'(seg) * ADDR_W'(TERMS) + ADDR_W'(j);
	endfunction

	// weight / derivative-factor multiplier
	logic signed [COEF_W-1:0] scl_a;
	logic signed [9:0]        scl_b;
	logic signed [57:0]       scl_p;
	logic signed [63:0]       lsum;
	logic signed [COEF_W-1:0] ecoef;
	logic signed [COEF_W-1:0] hsum;

	always_comb begin
		if (state_q == S_LSUM) begin
			scl_a = term_q[j_q];
			scl_b = LOAD_W[k_q][j_q];
		end else begin
			scl_a = rd_coef;
			scl_b = signed'({5'b0, DERIV_F[m_q][j_q]});
		end
	end

	assign scl_p = scl_a * scl_b;
	assign lsum  = lacc_q + 64'(scl_p);
	assign ecoef = sat48(64'(scl_p));
	assign hsum  = sat48(64'(mul_res) + 64'(scaled_q));

	assign ram_we    = (state_q == S_LSUM) && (j_q == J_TOP);
	assign ram_waddr = addr_of(seg_q, k_q);
	assign ram_wdata = sat48(lsum >>> 1);
	assign ram_raddr = addr_of(seg_q, j_q);

	// load segment duration, from the incoming beat
	logic        ld_seg;
	logic [31:0] ld_t0, ld_t1, ld_dt;

	assign ld_seg = in_data.segment;
	assign ld_t0  = ld_seg ? apex_q : lift_q;
	assign ld_t1  = ld_seg ? touch_q : apex_q;
	assign ld_dt  = (ld_t1 >= ld_t0) ? ld_t1 - ld_t0 : 32'd0;

	// evaluate time clamp and segment pick; upper clamp applied last
	logic [31:0] ev_t1, ev_t2, ev_t0, ev_inv, ev_d;
	logic        ev_lo, ev_hi, ev_seg;

	assign ev_lo  = in_q.query_time < lift_q;
	assign ev_t1  = ev_lo ? lift_q : in_q.query_time;
	assign ev_hi  = ev_t1 > touch_q;
	assign ev_t2  = ev_hi ? touch_q : ev_t1;
	assign ev_seg = !(ev_t2 < apex_q);
	assign ev_t0  = ev_seg ? apex_q : lift_q;
	assign ev_inv = ev_seg ? rinv_q : linv_q;
	assign ev_d   = (ev_t2 >= ev_t0) ? ev_t2 - ev_t0 : 32'd0;

	// multiplier operand selection
	always_comb begin
		mul_start = 1'b0;
		mul_a     = p_q;
		mul_b     = inv_q;
		case (state_q)
			S_LMUL: begin
				mul_start = 1'b1;
				mul_b     = dt_q;
				case (mi_q)
					MI_V1:   mul_a = COEF_W'(in_q.start_velocity);
					MI_SA:   mul_a = COEF_W'(in_q.start_acceleration);
					MI_V3:   mul_a = COEF_W'(in_q.end_velocity);
					MI_EA:   mul_a = COEF_W'(in_q.end_acceleration);
					default: mul_a = tmp_q;
				endcase
			end
			S_ETN: begin
				mul_start = 1'b1;
				mul_a     = signed'({16'b0, d_q});
				mul_b     = inv_q;
			end
			S_ESC: begin
				mul_start = (j_q != J_TOP);
				mul_b     = {15'b0, tn_q};
			end
			S_EFS: begin
				mul_start = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			loaded_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q         <= in_data;
						dt_q         <= ld_dt;
						seg_q        <= ld_seg;
						mi_q         <= MI_V1;
						term_q[T_X1] <= COEF_W'(in_data.start_position);
						term_q[T_X2] <= COEF_W'(in_data.middle_height);
						term_q[T_X3] <= COEF_W'(in_data.end_position);
						state_q      <= (in_data.operation == OP_LOAD) ? S_LMUL : S_EPREP;
					end
				end
				S_LMUL: state_q <= S_LWAIT;
				S_LWAIT: begin
					if (mul_done) begin
						case (mi_q)
							MI_V1:   term_q[T_V1] <= mul_res;
							MI_A1:   term_q[T_A1] <= mul_res;
							MI_V3:   term_q[T_V3] <= mul_res;
							MI_A3:   term_q[T_A3] <= mul_res;
							default: tmp_q        <= mul_res;
						endcase
						if (mi_q == MI_A3) begin
							k_q     <= '0;
							j_q     <= '0;
							lacc_q  <= '0;
							state_q <= S_LSUM;
						end else begin
							mi_q    <= mi_q + 3'd1;
							state_q <= S_LMUL;
						end
					end
				end
				S_LSUM: begin
					// one weighted term per cycle, coefficient written on the last
					if (j_q == J_TOP) begin
						lacc_q <= '0;
						j_q    <= '0;
						if (k_q == J_TOP) begin
							loaded_q[seg_q] <= 1'b1;
							state_q         <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						lacc_q <= lsum;
						j_q    <= j_q + 1'b1;
					end
				end
				S_EPREP: begin
					clamped_q <= ev_lo || ev_hi;
					seg_q     <= ev_seg;
					inv_q     <= ev_inv;
					d_q       <= ev_d;
					state_q   <= S_ETN;
				end
				S_ETN: state_q <= S_ETNW;
				S_ETNW: begin
					if (mul_done) begin
						tn_q    <= (mul_res > signed'({31'b0, ONE_Q})) ? ONE_Q : mul_res[16:0];
						m_q     <= 2'd0;
						j_q     <= J_TOP;
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ESC;
				S_ESC: begin
					scaled_q <= ecoef;
					if (j_q == J_TOP) begin
						p_q     <= ecoef;
						j_q     <= j_q - 1'b1;
						state_q <= S_ERD;
					end else begin
						state_q <= S_EHW;
					end
				end
				S_EHW: begin
					if (mul_done) begin
						if (j_q == J_W'(m_q)) begin
							if (m_q == 2'd0) begin
								pos_q   <= hsum;
								m_q     <= 2'd1;
								j_q     <= J_TOP;
								state_q <= S_ERD;
							end else begin
								p_q     <= hsum;
								fcnt_q  <= m_q;
								state_q <= S_EFS;
							end
						end else begin
							p_q     <= hsum;
							j_q     <= j_q - 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				S_EFS: state_q <= S_EFW;
				S_EFW: begin
					if (mul_done) begin
						p_q <= mul_res;
						if (fcnt_q == 2'd2) begin
							fcnt_q  <= 2'd1;
							state_q <= S_EFS;
						end else if (m_q == 2'd1) begin
							vel_q   <= mul_res;
							m_q     <= 2'd2;
							j_q     <= J_TOP;
							state_q <= S_ERD;
						end else begin
							state_q <= S_EOUT;
						end
					end
				end
				S_EOUT: begin
					// wait here while the previous result is still held
					if (!out_valid_q || out_ready) begin
						out_q.position_out     <= sat32(pos_q);
						out_q.velocity_out     <= sat32(vel_q);
						out_q.acceleration_out <= sat32(p_q);
						out_q.time_clamped     <= clamped_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat held until taken; a new one loads as the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EOUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a new result beat only comes out of the final evaluate step
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EOUT))
		else $error("result beat without an evaluate");

	// normalized time never exceeds one while the coefficients are walked
	a_tn_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERD) |-> (tn_q <= ONE_Q))
		else $error("normalized time above one");

	// a segment becomes valid only when its last coefficient is written
	a_loaded_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(loaded_q != $past(loaded_q)) |-> $past(ram_we && k_q == J_TOP))
		else $error("segment marked loaded outside a load");

endmodule
